FILE: rtl/core/kdpc_pkg.sv
// Package for the key debounce / press classifier.
// Holds register reset values, configuration indexes and the shared structs.
// No dependencies.
package kdpc_pkg;

  localparam int KEY_W    = 3;
  localparam int CODE_W   = 4;
  localparam int CNT8_W   = 8;
  localparam int CNT9_W   = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic              INVERT_INPUT_DEF = 1'b1;
  localparam logic [CODE_W-1:0] HOME_CODE_DEF    = 4'd8;

  localparam logic [KEY_W-1:0] KEY_MASK   = 3'h7;
  localparam logic [CNT9_W-1:0] SPECIAL_WINDOW = 9'd30;

  // register reset values
  localparam logic [KEY_W-1:0]  RST_SPECIAL_COMBO      = 3'd3;
  localparam logic [CNT8_W-1:0] RST_RELEASE_TICKS      = 8'd10;
  localparam logic [CNT8_W-1:0] RST_SPECIAL_LONG_TICKS = 8'd200;
  localparam logic [CNT8_W-1:0] RST_SPECIAL_SHORT_MIN  = 8'd10;
  localparam logic [CNT8_W-1:0] RST_SHORT_TICKS        = 8'd10;
  localparam logic [CNT8_W-1:0] RST_REPEAT_FIRST       = 8'd100;
  localparam logic [CNT8_W-1:0] RST_REPEAT_INTERVAL    = 8'd20;
  localparam logic [CNT8_W-1:0] RST_LONG_REPEATS       = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPECIAL_COMBO      = 3'd0,
    CFG_RELEASE_TICKS      = 3'd1,
    CFG_SPECIAL_LONG_TICKS = 3'd2,
    CFG_SPECIAL_SHORT_MIN  = 3'd3,
    CFG_SHORT_TICKS        = 3'd4,
    CFG_REPEAT_FIRST       = 3'd5,
    CFG_REPEAT_INTERVAL    = 3'd6,
    CFG_LONG_REPEATS       = 3'd7
  } kdpc_cfg_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0]  special_combo;
    logic [CNT8_W-1:0] release_ticks;
    logic [CNT8_W-1:0] special_long_ticks;
    logic [CNT8_W-1:0] special_short_min;
    logic [CNT8_W-1:0] short_ticks;
    logic [CNT8_W-1:0] repeat_first;
    logic [CNT8_W-1:0] repeat_interval;
    logic [CNT8_W-1:0] long_repeats;
  } kdpc_cfg_t;

  // packed low field last so the struct maps straight onto out_tdata[9:0]
  typedef struct packed {
    logic [KEY_W-1:0]  event_key;
    logic              long_flag;
    logic              repeat_flag;
    logic              short_flag;
    logic [CODE_W-1:0] key_code;
  } kdpc_result_t;

  localparam int RESULT_W   = $bits(kdpc_result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;

endpackage

FILE: rtl/core/kdpc_core.sv
// Classifier core: press state registers and the one-tick update logic.
// Depends on kdpc_pkg.
module kdpc_core
  import kdpc_pkg::*;
#(
  parameter logic              INVERT_INPUT = INVERT_INPUT_DEF,
  parameter logic [CODE_W-1:0] HOME_CODE    = HOME_CODE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [KEY_W-1:0] raw_keys,
  input  kdpc_cfg_t        cfg,
  output kdpc_result_t     result
);

  logic              release_wait_r,  release_wait_nxt;
  logic [CNT8_W-1:0] release_count_r, release_count_nxt;
  logic [CNT8_W-1:0] special_count_r, special_count_nxt;
  logic [CNT9_W-1:0] stable_count_r,  stable_count_nxt;
  logic [CNT9_W-1:0] repeat_count_r,  repeat_count_nxt;
  logic [KEY_W-1:0]  prev_keys_r,     prev_keys_nxt;

  always_comb begin
    logic [KEY_W-1:0]  keys;
    logic [CNT8_W-1:0] rc_inc;
    logic [CNT8_W-1:0] sc_inc;
    logic [CNT9_W-1:0] st_inc;
    logic [CNT9_W-1:0] rep_thr;
    logic [CNT9_W-1:0] ssm_hi;
    logic [CODE_W-1:0] code;
    logic              f_short;
    logic              f_repeat;
    logic              f_long;

    keys    = INVERT_INPUT ? (~raw_keys & KEY_MASK) : raw_keys;
    rc_inc  = release_count_r + 8'd1;
    sc_inc  = special_count_r + 8'd1;
    st_inc  = stable_count_r + 9'd1;
    rep_thr = {1'b0, cfg.repeat_first} + {1'b0, cfg.repeat_interval};
    ssm_hi  = {1'b0, cfg.special_short_min} + SPECIAL_WINDOW;
    code     = '0;
    f_short  = 1'b0;
    f_repeat = 1'b0;
    f_long   = 1'b0;

    release_wait_nxt  = release_wait_r;
    release_count_nxt = release_count_r;
    special_count_nxt = special_count_r;
    stable_count_nxt  = stable_count_r;
    repeat_count_nxt  = repeat_count_r;
    prev_keys_nxt     = keys;

    // special combination / release wait
    if (release_wait_r) begin
      if (keys == '0) begin
        if (rc_inc >= cfg.release_ticks) begin
          release_count_nxt = '0;
          release_wait_nxt  = 1'b0;
        end else begin
          release_count_nxt = rc_inc;
        end
      end else begin
        release_count_nxt = '0;
      end
    end else if (keys == cfg.special_combo) begin
      if (sc_inc >= cfg.special_long_ticks) begin
        special_count_nxt = '0;
        code              = HOME_CODE;
        f_long            = 1'b1;
        release_wait_nxt  = 1'b1;
      end else begin
        special_count_nxt = sc_inc;
      end
    end else begin
      if ((special_count_r >= cfg.special_short_min) &&
          ({1'b0, special_count_r} < ssm_hi)) begin
        code    = {1'b0, cfg.special_combo};
        f_short = 1'b1;
      end
      special_count_nxt = '0;
    end

    // normal keys: debounce, auto-repeat, long
    if ((keys == '0) || (keys != prev_keys_r) || (keys == cfg.special_combo)) begin
      stable_count_nxt = '0;
      repeat_count_nxt = '0;
    end else begin
      stable_count_nxt = st_inc;
      if (st_inc == {1'b0, cfg.short_ticks}) begin
        code    = {1'b0, keys};
        f_short = 1'b1;
      end
      if (st_inc == rep_thr) begin
        code             = {1'b0, keys};
        f_repeat         = 1'b1;
        stable_count_nxt = {1'b0, cfg.repeat_first};
        repeat_count_nxt = repeat_count_r + 9'd1;
      end
      if (repeat_count_nxt == {1'b0, cfg.long_repeats}) begin
        code             = {1'b0, keys};
        f_long           = 1'b1;
        repeat_count_nxt = {1'b0, cfg.long_repeats} + 9'd1;
      end
    end

    result.key_code    = code;
    result.short_flag  = f_short;
    result.repeat_flag = f_repeat;
    result.long_flag   = f_long;
    result.event_key   = (f_short && ((code == 4'd1) || (code == 4'd2) || (code == 4'd4)))
                         ? code[KEY_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_wait_r  <= 1'b0;
      release_count_r <= '0;
      special_count_r <= '0;
      stable_count_r  <= '0;
      repeat_count_r  <= '0;
      prev_keys_r     <= '0;
    end else if (step_en) begin
      release_wait_r  <= release_wait_nxt;
      release_count_r <= release_count_nxt;
      special_count_r <= special_count_nxt;
      stable_count_r  <= stable_count_nxt;
      repeat_count_r  <= repeat_count_nxt;
      prev_keys_r     <= prev_keys_nxt;
    end
  end

  // the special counter is parked at zero for the whole release wait
  a_wait_no_special: assert property (@(posedge clk) disable iff (!rst_n)
    release_wait_r |-> (special_count_r == '0))
    else $error("special count moved during release wait");

  // a repeat event always rewinds the stable counter to repeat_first
  a_repeat_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && result.repeat_flag) |=> (stable_count_r == {1'b0, $past(cfg.repeat_first)}))
    else $error("stable count not rewound after repeat");

  // a posted key only comes with a short press of a single key
  a_event_short: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (result.event_key != '0)) |->
      (result.short_flag && ($countones(result.key_code) == 1) && !result.key_code[3]))
    else $error("event key without single-key short press");

endmodule

FILE: rtl/core/kdpc_skid.sv
// Two-entry output buffer for result items; ready is taken from a register.
// Depends on kdpc_pkg.
module kdpc_skid
  import kdpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  kdpc_result_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output kdpc_result_t pop_data
);

  logic         main_v_r, main_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  kdpc_result_t main_r,   main_nxt;
  kdpc_result_t skid_r,   skid_nxt;
  logic         push;
  logic         pop;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // the spare entry is only ever filled behind a full head entry
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid with empty head");

endmodule

FILE: rtl/core/key_debounce_press_classifier_top.sv
// Top level of the key debounce / press classifier: config registers,
// input register, classifier core and output buffer.
// Depends on kdpc_pkg, kdpc_core, kdpc_skid.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready | in_tdata[2:0] raw_keys (one tick)
//  out_    | out | out_tvalid/out_tready | out_tdata[9:0] code, flags, event key
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[7:0]
//
// One result item per input item; one item per cycle sustained while out_tready
// stays high. The input item is registered, then the core's update result is
// registered in the output buffer. The output buffer has two entries and its
// ready comes from a register, so a stall on out_ lets one more item in before
// in_tready drops. cfg_ready is always high. Reset (rst_n low, synchronous)
// clears all press state and loads the register defaults.
module key_debounce_press_classifier_top
  import kdpc_pkg::*;
#(
  parameter logic              INVERT_INPUT = INVERT_INPUT_DEF,
  parameter logic [CODE_W-1:0] HOME_CODE    = HOME_CODE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input ticks
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [2:0] raw_keys, rest zero
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] key_code, [4] short_flag,
                                            // [5] repeat_flag, [6] long_flag,
                                            // [9:7] event_key, rest zero
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT8_W-1:0]     cfg_data
);

  kdpc_cfg_t        cfg_r;
  logic             in_v_r;
  logic [KEY_W-1:0] in_keys_r;
  logic             buf_ready;
  logic             step_en;
  kdpc_result_t     step_result;
  kdpc_result_t     out_result;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.special_combo      <= RST_SPECIAL_COMBO;
      cfg_r.release_ticks      <= RST_RELEASE_TICKS;
      cfg_r.special_long_ticks <= RST_SPECIAL_LONG_TICKS;
      cfg_r.special_short_min  <= RST_SPECIAL_SHORT_MIN;
      cfg_r.short_ticks        <= RST_SHORT_TICKS;
      cfg_r.repeat_first       <= RST_REPEAT_FIRST;
      cfg_r.repeat_interval    <= RST_REPEAT_INTERVAL;
      cfg_r.long_repeats       <= RST_LONG_REPEATS;
    end else if (cfg_valid && cfg_ready) begin
      case (kdpc_cfg_idx_t'(cfg_index))
        CFG_SPECIAL_COMBO:      cfg_r.special_combo      <= cfg_data[KEY_W-1:0];
        CFG_RELEASE_TICKS:      cfg_r.release_ticks      <= cfg_data;
        CFG_SPECIAL_LONG_TICKS: cfg_r.special_long_ticks <= cfg_data;
        CFG_SPECIAL_SHORT_MIN:  cfg_r.special_short_min  <= cfg_data;
        CFG_SHORT_TICKS:        cfg_r.short_ticks        <= cfg_data;
        CFG_REPEAT_FIRST:       cfg_r.repeat_first       <= cfg_data;
        CFG_REPEAT_INTERVAL:    cfg_r.repeat_interval    <= cfg_data;
        CFG_LONG_REPEATS:       cfg_r.long_repeats       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: the core steps when it holds an item and the buffer has room
  assign step_en   = in_v_r && buf_ready;
  assign in_tready = !in_v_r || buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_keys_r <= in_tdata[KEY_W-1:0];
    end
  end

  kdpc_core #(
    .INVERT_INPUT (INVERT_INPUT),
    .HOME_CODE    (HOME_CODE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .raw_keys (in_keys_r),
    .cfg      (cfg_r),
    .result   (step_result)
  );

  kdpc_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_v_r),
    .push_ready (buf_ready),
    .push_data  (step_result),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_result)
  );

  assign out_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, out_result};

endmodule
